// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Entry layout, control group between the top level and the cells, and the
// status codes returned with every result item.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Number of cells in the sorted chain
  localparam int CAPACITY = 16;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int PRI_W   = 8;
  localparam int CNT_W   = 5;
  localparam int ST_W    = 2;

  // Stream payload widths, whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // One held entry
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRI_W-1:0]   pri;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On an enqueue it keeps its entry, takes the new entry or
// takes its left neighbor's entry; on a dequeue it takes its right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::spq_ctrl_t ctrl,       // broadcast command
  input  wire logic              occ,        // slot holds a live entry
  input  wire logic              left_ins,   // left neighbor is at or past insert point
  input  wire spq_pkg::spq_entry_t left_entry,
  input  wire spq_pkg::spq_entry_t right_entry,
  output logic                   ins,        // this slot is at or past insert point
  output spq_pkg::spq_entry_t    entry
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // A slot is at or past the insert point when it is free or holds a
  // strictly larger priority; equal priorities stay ahead of the new one.
  assign ins = !occ || (entry_r.pri > ctrl.new_entry.pri);

  // Pick the next entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq) begin
      if (ins && !left_ins) begin
        entry_nxt = ctrl.new_entry;
      end else if (ins) begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
// A result item is registered in the cycle after its input item is accepted.
// Throughput: one item per cycle; every cell of the chain compares the new
// priority at once and shifts in the same cycle, with the result register
// taking the next item while out_tready is high.
// Reset: rst_n (synchronous, active low) empties the queue and clears out_tvalid;
// entry contents are left as they are.
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable priority queue on a chain of cells
// Smaller priority leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [spq_pkg::IN_DATA_W-1:0]    in_tdata,   // item_value[31:0], item_priority[39:32]
  input  wire logic                             in_tuser,   // operation[0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]        out_tdata,  // out_value[31:0], out_priority[39:32], occupancy[44:40], zero[47:45]
  output logic [spq_pkg::ST_W-1:0]              out_tuser   // status[1:0]
);
  import spq_pkg::*;

  logic                 accept;
  logic                 full;
  logic                 empty;
  spq_ctrl_t            ctrl;
  spq_entry_t           entries [CAPACITY];
  logic                 ins     [CAPACITY];

  logic [CNT_W-1:0]     count_r,    count_nxt;
  logic                 out_vld_r,  out_vld_nxt;
  logic [ST_W-1:0]      st_r,       st_nxt;
  logic [VALUE_W-1:0]   val_r,      val_nxt;
  logic [PRI_W-1:0]     pri_r,      pri_nxt;
  logic [CNT_W-1:0]     occ_out_r,  occ_out_nxt;

  // Take a new item whenever the result register is free or being drained
  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  // Broadcast command to the chain
  always_comb begin
    ctrl.enq           = accept && (in_tuser == OP_ENQ) && !full;
    ctrl.deq           = accept && (in_tuser == OP_DEQ) && !empty;
    ctrl.new_entry.value = in_tdata[VALUE_W-1:0];
    ctrl.new_entry.pri   = in_tdata[VALUE_W +: PRI_W];
  end

  // Chain of cells, head at index 0
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic       occ;
    logic       left_ins;
    spq_entry_t left_entry;
    spq_entry_t right_entry;

    assign occ = (CNT_W'(k) < count_r);

    if (k == 0) begin : g_head
      assign left_ins   = 1'b0;
      assign left_entry = ctrl.new_entry;
    end else begin : g_mid
      assign left_ins   = ins[k-1];
      assign left_entry = entries[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[k];
    end else begin : g_body
      assign right_entry = entries[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_ins    (left_ins),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ins         (ins[k]),
      .entry       (entries[k])
    );
  end

  // Count and result
  always_comb begin
    count_nxt   = count_r;
    out_vld_nxt = out_vld_r && !out_tready;
    st_nxt      = st_r;
    val_nxt     = val_r;
    pri_nxt     = pri_r;
    occ_out_nxt = occ_out_r;
    if (accept) begin
      out_vld_nxt = 1'b1;
      st_nxt      = ST_OK;
      val_nxt     = '0;
      pri_nxt     = '0;
      if (in_tuser == OP_ENQ) begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          val_nxt   = entries[0].value;
          pri_nxt   = entries[0].pri;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      occ_out_nxt = count_nxt;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    st_r      <= st_nxt;
    val_r     <= val_nxt;
    pri_r     <= pri_nxt;
    occ_out_r <= occ_out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {3'b000, occ_out_r, pri_r, val_r};

endmodule

`default_nettype wire
